/* design/riblk_pkg.sv */
// ----------------------------------------------------------------------------
// riblk_pkg
// Shared types and constants for the row interval block index.
// ----------------------------------------------------------------------------
package riblk_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

	typedef enum logic [2:0] {
		CMD_INSERT = 3'd0,
		CMD_REMOVE = 3'd1,
		CMD_LOCATE = 3'd2,
		CMD_NEXT   = 3'd3,
		CMD_RANGE  = 3'd4
	} cmd_e_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOTFOUND = 3'd1,
		ST_BEYOND   = 3'd2,
		ST_OVERLAP  = 3'd3,
		ST_FULL     = 3'd4,
		ST_EMPTY    = 3'd5
	} status_e_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EVAL = 2'd1,
		S_EXEC = 2'd2
	} state_t;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [63:0] key_id;
		logic signed [63:0] query_upper;
		logic [31:0]        new_span;
		logic [63:0]        new_page;
		logic [31:0]        new_gen;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [63:0] hit_start;
		logic [31:0]        hit_span;
		logic [63:0]        hit_page;
		logic [31:0]        hit_gen;
		logic signed [63:0] span_upper;
		logic [8:0]         entry_total;
	} rsp_t;

	typedef struct packed {
		logic cap;
		logic eval;
		logic exec;
	} ctl_t;

	typedef struct packed {
		logic load_ok;
	} dp_stat_t;

endpackage

/* design/riblk_ctrl.sv */
// ----------------------------------------------------------------------------
// riblk_ctrl
// Sequencer: capture request, evaluate cell compares, execute and respond.
// ----------------------------------------------------------------------------
module riblk_ctrl import riblk_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  dp_stat_t stat,
	output ctl_t     ctl
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		ctl       = '0;
		req_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					ctl.cap  = 1'b1;
					state_nx = S_EVAL;
				end
			end
			S_EVAL: begin
				ctl.eval = 1'b1;
				state_nx = S_EXEC;
			end
			S_EXEC: begin
				// next request overlaps the finishing cycle
				req_stall = !stat.load_ok;
				if (stat.load_ok) begin
					ctl.exec = 1'b1;
					if (req_valid) begin
						ctl.cap  = 1'b1;
						state_nx = S_EVAL;
					end else begin
						state_nx = S_IDLE;
					end
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

endmodule

/* design/riblk_datapath.sv */
// ----------------------------------------------------------------------------
// riblk_datapath
// Sorted cell chain with parallel compares, hit select, shift and result reg.
// ----------------------------------------------------------------------------
module riblk_datapath import riblk_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  ctl_t     ctl,
	input  req_t     req,
	input  logic     rsp_stall,
	output logic     rsp_valid,
	output rsp_t     rsp,
	output dp_stat_t stat
);

	localparam int N = TABLE_DEPTH;

	// captured request
	logic [2:0]  cmd_q;
	logic [63:0] kb_q, ub_q, page_q;
	logic [31:0] span_q, gen_q;

	// cells, start and end kept in biased (unsigned-ordered) form
	logic [63:0] st_q [N];
	logic [63:0] en_q [N];
	logic [31:0] sp_q [N];
	logic [63:0] pg_q [N];
	logic [31:0] gn_q [N];
	logic [CNT_W-1:0] count_q;

	logic [N-1:0] above, ge, above_s1, ge_s1, sel, last;
	logic [64:0]  eb, eb_s1;

	logic [63:0] h_st, h_en, h_pg, l_en;
	logic [31:0] h_sp, h_gn;
	logic        found, do_ins, do_rem;
	logic [2:0]  st_code;
	rsp_t        r_nx;
	logic [CNT_W-1:0] count_nx;

	logic rsp_valid_q;
	rsp_t rsp_q;

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			cmd_q  <= req.cmd;
			kb_q   <= req.key_id ^ SIGN64;
			ub_q   <= req.query_upper ^ SIGN64;
			span_q <= req.new_span;
			page_q <= req.new_page;
			gen_q  <= req.new_gen;
		end
	end

	// ends are sorted, so above is a thermometer code
	always_comb begin
		for (int j = 0; j < N; j++) begin
			above[j] = (count_q > CNT_W'(j)) && (kb_q < en_q[j]);
			ge[j]    = above[j] || (count_q == CNT_W'(j));
		end
		eb = {1'b0, kb_q} + {33'd0, span_q};
	end

	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			above_s1 <= above;
			ge_s1    <= ge;
			eb_s1    <= eb;
		end
	end

	always_comb begin
		h_st = '0; h_en = '0; h_pg = '0; l_en = '0; h_sp = '0; h_gn = '0;
		for (int j = 0; j < N; j++) begin
			sel[j]  = ge_s1[j] && ((j == 0) || !ge_s1[(j == 0) ? 0 : j - 1]);
			last[j] = (count_q == CNT_W'(j + 1));
			h_st |= {64{sel[j]}} & st_q[j];
			h_en |= {64{sel[j]}} & en_q[j];
			h_pg |= {64{sel[j]}} & pg_q[j];
			h_sp |= {32{sel[j]}} & sp_q[j];
			h_gn |= {32{sel[j]}} & gn_q[j];
			l_en |= {64{last[j]}} & en_q[j];
		end
		found = |above_s1;
	end

	always_comb begin
		st_code  = ST_OK;
		do_ins   = 1'b0;
		do_rem   = 1'b0;
		r_nx     = '0;
		count_nx = count_q;
		case (cmd_q)
			CMD_INSERT: begin
				if (span_q == 32'd0) begin
					st_code = ST_OVERLAP;
				end else if (eb_s1[64]) begin
					st_code = ST_BEYOND;
				end else if (found && (eb_s1 > {1'b0, h_st})) begin
					st_code = ST_OVERLAP;
				end else if (count_q == CNT_W'(N)) begin
					st_code = ST_FULL;
				end else begin
					do_ins         = 1'b1;
					count_nx       = count_q + 1'b1;
					r_nx.hit_start = kb_q ^ SIGN64;
					r_nx.hit_span  = span_q;
					r_nx.hit_page  = page_q;
					r_nx.hit_gen   = gen_q;
				end
			end
			CMD_REMOVE, CMD_LOCATE, CMD_NEXT: begin
				if (!found) begin
					st_code = ST_NOTFOUND;
				end else if (cmd_q != CMD_NEXT && kb_q < h_st) begin
					st_code = ST_NOTFOUND;
				end else if (cmd_q == CMD_LOCATE && ub_q > h_en) begin
					st_code = ST_BEYOND;
				end else begin
					r_nx.hit_start = h_st ^ SIGN64;
					r_nx.hit_span  = h_sp;
					r_nx.hit_page  = h_pg;
					r_nx.hit_gen   = h_gn;
					if (cmd_q == CMD_REMOVE) begin
						do_rem   = 1'b1;
						count_nx = count_q - 1'b1;
					end
				end
			end
			CMD_RANGE: begin
				if (count_q == '0) begin
					st_code = ST_EMPTY;
				end else begin
					r_nx.hit_start  = st_q[0] ^ SIGN64;
					r_nx.span_upper = l_en ^ SIGN64;
				end
			end
			default: st_code = ST_NOTFOUND;
		endcase
		r_nx.status      = st_code;
		r_nx.entry_total = 9'(count_nx);
	end

	// cell chain: insert shifts up from the hit, remove shifts down into it
	for (genvar j = 0; j < N; j++) begin : g_cell
		always_ff @(posedge clk) begin
			if (ctl.exec && do_ins) begin
				if (sel[j]) begin
					st_q[j] <= kb_q;
					en_q[j] <= eb_s1[63:0];
					sp_q[j] <= span_q;
					pg_q[j] <= page_q;
					gn_q[j] <= gen_q;
				end else if (ge_s1[j] && j > 0) begin
					st_q[j] <= st_q[(j > 0) ? j - 1 : 0];
					en_q[j] <= en_q[(j > 0) ? j - 1 : 0];
					sp_q[j] <= sp_q[(j > 0) ? j - 1 : 0];
					pg_q[j] <= pg_q[(j > 0) ? j - 1 : 0];
					gn_q[j] <= gn_q[(j > 0) ? j - 1 : 0];
				end
			end else if (ctl.exec && do_rem && above_s1[j] && j < N - 1) begin
				st_q[j] <= st_q[(j < N - 1) ? j + 1 : j];
				en_q[j] <= en_q[(j < N - 1) ? j + 1 : j];
				sp_q[j] <= sp_q[(j < N - 1) ? j + 1 : j];
				pg_q[j] <= pg_q[(j < N - 1) ? j + 1 : j];
				gn_q[j] <= gn_q[(j < N - 1) ? j + 1 : j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.exec) begin
				count_q     <= count_nx;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			rsp_q <= r_nx;
		end
	end

	assign stat.load_ok = !rsp_valid_q || !rsp_stall;
	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;

endmodule

/* design/row_interval_block_index_top.sv */
// Flow: the request is captured, the cell-chain compare is registered in the
//   evaluate step, select/shift and the response in the execute step (held by a
//   response stall); a new request is taken only when idle or as execute finishes.
// Reset: arst_n clears the sequencer, entry count and response valid; cell
//   contents stay undefined until written.
// ----------------------------------------------------------------------------
// row_interval_block_index_top
// Ordered non-overlapping interval table with insert, remove, locate, next, range.
// ----------------------------------------------------------------------------
module row_interval_block_index_top import riblk_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	ctl_t     ctl;
	dp_stat_t stat;

	riblk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	riblk_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.req       (req),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.stat      (stat)
	);

`ifndef SYNTH
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted on back-to-back cycles");
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.entry_total <= 9'(TABLE_DEPTH)))
		else $error("entry total above table depth");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != ST_OK) |->
		(rsp.hit_start == '0 && rsp.span_upper == '0 && rsp.hit_page == '0))
		else $error("failed response carries data");
	a_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |-> $past(ctl.eval) || $past(ctl.exec) == 1'b0)
		else $error("execute without evaluate");
`endif

endmodule
